// ----- design/bcbp_pkg.sv -----
// Shared types and constants for the box-constrained Babai point solver.
// No dependencies; used by bcbp_ctrl, bcbp_dp and box_constrained_babai_point.
package bcbp_pkg;

   localparam int MAX_SIZE    = 16;
   localparam int VALUE_WIDTH = 24;
   localparam int EST_W       = 16;
   localparam int IDX_W       = $clog2(MAX_SIZE);
   localparam int CNT_W       = IDX_W + 1;
   localparam int TRI_DEPTH   = (MAX_SIZE * (MAX_SIZE + 1)) / 2;
   localparam int TRI_AW      = $clog2(TRI_DEPTH);
   localparam int PROD_W      = VALUE_WIDTH + EST_W;
   localparam int ACC_W       = PROD_W + IDX_W + 2;
   localparam int DIV_CW      = $clog2(ACC_W);
   localparam int EST_MAX     = (2 ** (EST_W - 1)) - 1;
   localparam int EST_MIN_MAG = 2 ** (EST_W - 1);

   typedef enum logic [1:0] {
      CMD_MATRIX = 2'd0,
      CMD_TARGET = 2'd1,
      CMD_SOLVE  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_SIZE  = 2'd0,
      CSR_BOX   = 2'd1,
      CSR_UPPER = 2'd2,
      CSR_NONE  = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [1:0]                    command;
      logic [3:0]                    row;
      logic [3:0]                    column;
      logic signed [VALUE_WIDTH-1:0] entry_value;
   } req_type;

   typedef struct packed {
      logic [3:0]              position;
      logic signed [EST_W-1:0] estimate;
      logic                    zero_pivot;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic             load;
      logic             acc_clr;
      logic             mul;
      logic             acc_add;
      logic             div_ld;
      logic             div_step;
      logic             fin;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } dp_cmd_type;

   typedef struct packed {
      logic diag_zero;
      logic rsp_free;
   } dp_sts_type;

   function automatic logic [TRI_AW-1:0] tri_index(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
      logic [TRI_AW+1:0] rr;
      logic [TRI_AW+1:0] cc;
      logic [TRI_AW+1:0] p;
      rr = (TRI_AW+2)'(r);
      cc = (TRI_AW+2)'(c);
      p  = (TRI_AW+2)'(rr * ((TRI_AW+2)'(2 * MAX_SIZE + 1) - rr));
      return TRI_AW'((p >> 1) + cc - rr);
   endfunction

endpackage

// ----- design/bcbp_dp.sv -----
// Datapath: triangle, target and estimate memories, MAC, restoring divider,
// rounding/clamp and result register. Depends on bcbp_pkg.
module bcbp_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  bcbp_pkg::dp_cmd_type cmd,
   output bcbp_pkg::dp_sts_type sts,
   input  bcbp_pkg::req_type    req_data,
   input  logic                 box_constrained,
   input  logic [7:0]           upper_limit,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bcbp_pkg::rsp_type    rsp_data
);

   localparam int VW = bcbp_pkg::VALUE_WIDTH;
   localparam int AW = bcbp_pkg::ACC_W;
   localparam int EW = bcbp_pkg::EST_W;

   logic signed [VW-1:0] tri_mem [bcbp_pkg::TRI_DEPTH];
   logic signed [VW-1:0] tgt_mem [bcbp_pkg::MAX_SIZE];
   logic signed [EW-1:0] est_mem [bcbp_pkg::MAX_SIZE];

   logic signed [VW-1:0]                tri_rd_ff;
   logic signed [VW-1:0]                tgt_rd_ff;
   logic signed [EW-1:0]                est_rd_ff;
   logic signed [bcbp_pkg::PROD_W-1:0]  prod_ff;
   logic signed [AW-1:0]                acc_ff;
   logic [AW-1:0]                       quo_ff;
   logic [VW-1:0]                       rem_ff;
   logic [VW-1:0]                       dm_ff;
   logic                                neg_ff;
   logic                                zp_ff;
   logic                                rsp_valid_ff;
   bcbp_pkg::rsp_type                   rsp_ff;

   logic                          wr_tri;
   logic                          wr_tgt;
   logic [bcbp_pkg::TRI_AW-1:0]   waddr;
   logic [bcbp_pkg::TRI_AW-1:0]   raddr;
   logic signed [AW-1:0]          residual;
   logic [VW:0]                   sh;
   logic                          ge;
   logic [VW:0]                   rem_next;
   logic                          rnd;
   logic [AW:0]                   qr;
   logic signed [EW-1:0]          est;

   assign wr_tri = cmd.load && (req_data.command == bcbp_pkg::CMD_MATRIX)
                   && (int'(req_data.row) < bcbp_pkg::MAX_SIZE)
                   && (int'(req_data.column) < bcbp_pkg::MAX_SIZE)
                   && (req_data.column >= req_data.row);
   assign wr_tgt = cmd.load && (req_data.command == bcbp_pkg::CMD_TARGET)
                   && (int'(req_data.row) < bcbp_pkg::MAX_SIZE);
   assign waddr = bcbp_pkg::tri_index(req_data.row[bcbp_pkg::IDX_W-1:0],
                                      req_data.column[bcbp_pkg::IDX_W-1:0]);
   assign raddr = bcbp_pkg::tri_index(cmd.row, cmd.col);

   always_ff @(posedge clock) begin
      if (wr_tri) begin
         tri_mem[waddr] <= req_data.entry_value;
      end
      if (wr_tgt) begin
         tgt_mem[req_data.row[bcbp_pkg::IDX_W-1:0]] <= req_data.entry_value;
      end
      if (cmd.fin) begin
         est_mem[cmd.row] <= est;
      end
      tri_rd_ff <= tri_mem[raddr];
      tgt_rd_ff <= tgt_mem[cmd.row];
      est_rd_ff <= est_mem[cmd.col];
   end

   assign residual = AW'(tgt_rd_ff) - acc_ff;
   assign sh       = {rem_ff, quo_ff[AW-1]};
   assign ge       = sh >= {1'b0, dm_ff};
   assign rem_next = ge ? (sh - {1'b0, dm_ff}) : sh;
   assign rnd      = {rem_ff, 1'b0} >= {1'b0, dm_ff};
   assign qr       = {1'b0, quo_ff} + (AW+1)'(rnd);

   always_comb begin
      priority if (zp_ff) begin
         est = '0;
      end else if (box_constrained) begin
         if (neg_ff) begin
            est = '0;
         end else if (qr > (AW+1)'(upper_limit)) begin
            est = EW'(upper_limit);
         end else begin
            est = EW'(qr);
         end
      end else if (neg_ff) begin
         if (qr > (AW+1)'(bcbp_pkg::EST_MIN_MAG)) begin
            est = EW'(bcbp_pkg::EST_MIN_MAG);
         end else begin
            est = EW'(0) - qr[EW-1:0];
         end
      end else if (qr > (AW+1)'(bcbp_pkg::EST_MAX)) begin
         est = EW'(bcbp_pkg::EST_MAX);
      end else begin
         est = EW'(qr);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= tri_rd_ff * est_rd_ff;
      end
      if (cmd.acc_clr) begin
         acc_ff <= '0;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + AW'(prod_ff);
      end
      if (cmd.div_ld) begin
         neg_ff <= residual[AW-1] ^ tri_rd_ff[VW-1];
         zp_ff  <= tri_rd_ff == '0;
         quo_ff <= residual[AW-1] ? (AW'(0) - residual) : residual;
         rem_ff <= '0;
         dm_ff  <= tri_rd_ff[VW-1] ? (VW'(0) - tri_rd_ff) : tri_rd_ff;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[AW-2:0], ge};
         rem_ff <= rem_next[VW-1:0];
      end
      if (cmd.fin) begin
         rsp_ff.position   <= 4'(cmd.row);
         rsp_ff.estimate   <= est;
         rsp_ff.zero_pivot <= zp_ff;
         rsp_ff.last       <= cmd.row == '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.fin) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign sts.diag_zero = tri_rd_ff == '0;
   assign sts.rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

endmodule

// ----- design/bcbp_ctrl.sv -----
// Controller: sequences loads, per-row MAC, division and result hand-off.
// Depends on bcbp_pkg; drives bcbp_dp through dp_cmd_type.
module bcbp_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  bcbp_pkg::req_type             req_data,
   input  logic [bcbp_pkg::CNT_W-1:0]    n_rows,
   output bcbp_pkg::dp_cmd_type          cmd,
   input  bcbp_pkg::dp_sts_type          sts
);

   typedef enum logic [3:0] {
      S_IDLE, S_ROW, S_MAC_RD, S_MAC_MUL, S_MAC_ACC, S_DG_RD, S_DG_LD, S_DIV, S_FIN
   } state_type;

   state_type                      state_ff;
   logic [bcbp_pkg::IDX_W-1:0]     i_ff;
   logic [bcbp_pkg::CNT_W-1:0]     j_ff;
   logic [bcbp_pkg::DIV_CW-1:0]    cnt_ff;
   logic                           accept;

   assign req_stall = state_ff != S_IDLE;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd          = '0;
      cmd.load     = accept;
      cmd.acc_clr  = state_ff == S_ROW;
      cmd.mul      = state_ff == S_MAC_MUL;
      cmd.acc_add  = state_ff == S_MAC_ACC;
      cmd.div_ld   = state_ff == S_DG_LD;
      cmd.div_step = state_ff == S_DIV;
      cmd.fin      = (state_ff == S_FIN) && sts.rsp_free;
      cmd.row      = i_ff;
      cmd.col      = (state_ff == S_DG_RD) ? i_ff : j_ff[bcbp_pkg::IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept && (req_data.command == bcbp_pkg::CMD_SOLVE) && (n_rows != '0)) begin
                  i_ff     <= bcbp_pkg::IDX_W'(n_rows - 1'b1);
                  state_ff <= S_ROW;
               end
            end
            S_ROW: begin
               j_ff <= bcbp_pkg::CNT_W'(i_ff) + 1'b1;
               if ((bcbp_pkg::CNT_W'(i_ff) + 1'b1) < n_rows) begin
                  state_ff <= S_MAC_RD;
               end else begin
                  state_ff <= S_DG_RD;
               end
            end
            S_MAC_RD: state_ff <= S_MAC_MUL;
            S_MAC_MUL: state_ff <= S_MAC_ACC;
            S_MAC_ACC: begin
               j_ff <= j_ff + 1'b1;
               if ((j_ff + 1'b1) < n_rows) begin
                  state_ff <= S_MAC_RD;
               end else begin
                  state_ff <= S_DG_RD;
               end
            end
            S_DG_RD: state_ff <= S_DG_LD;
            S_DG_LD: begin
               cnt_ff <= '0;
               state_ff <= sts.diag_zero ? S_FIN : S_DIV;
            end
            S_DIV: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == bcbp_pkg::DIV_CW'(bcbp_pkg::ACC_W - 1)) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (sts.rsp_free) begin
                  if (i_ff == '0) begin
                     state_ff <= S_IDLE;
                  end else begin
                     i_ff     <= i_ff - 1'b1;
                     state_ff <= S_ROW;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTH
   a_fin_free: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |-> sts.rsp_free) else $error("result issued into busy slot");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) && (i_ff == '0) && sts.rsp_free |=> state_ff == S_IDLE)
      else $error("solve did not end after row zero");
   a_div_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (cnt_ff < bcbp_pkg::DIV_CW'(bcbp_pkg::ACC_W)))
      else $error("divider count overrun");
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |=> (state_ff == S_DIV) || (state_ff == S_FIN))
      else $error("divider left early");
`endif

endmodule

// ----- design/box_constrained_babai_point.sv -----
// Top level of the box-constrained Babai point solver: CSRs and wiring.
// Depends on bcbp_pkg, bcbp_ctrl and bcbp_dp.
//
//  channel | dir | handshake           | payload
//  req     | in  | req_valid/req_stall | req_data (command,row,column,entry_value)
//  rsp     | out | rsp_valid/rsp_stall | rsp_data (position,estimate,zero_pivot,last)
//  csr     | in  | csr_valid/csr_ready | csr_index, csr_data
//
// A solve runs, per row, a MAC over the columns right of the diagonal and a
// bit-serial restoring divide (skipped on zero pivot); the bit-serial divider dominates.
// reset is synchronous; CSRs return to size 16, constrained, upper 3.
// req_stall is high for the whole solve; rsp_stall holds the solve at the
// finish of each row until the result register frees.
module box_constrained_babai_point (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bcbp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bcbp_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_data
);

   logic [4:0]                  size_ff;
   logic                        box_ff;
   logic [7:0]                  upper_ff;
   logic [bcbp_pkg::CNT_W-1:0]  n_rows;
   bcbp_pkg::dp_cmd_type        cmd;
   bcbp_pkg::dp_sts_type        sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= 5'd16;
         box_ff   <= 1'b1;
         upper_ff <= 8'd3;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bcbp_pkg::CSR_SIZE:  size_ff  <= csr_data[4:0];
            bcbp_pkg::CSR_BOX:   box_ff   <= csr_data[0];
            bcbp_pkg::CSR_UPPER: upper_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign n_rows = (int'(size_ff) > bcbp_pkg::MAX_SIZE) ?
                   bcbp_pkg::CNT_W'(bcbp_pkg::MAX_SIZE) : bcbp_pkg::CNT_W'(size_ff);

   bcbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .n_rows    (n_rows),
      .cmd       (cmd),
      .sts       (sts)
   );

   bcbp_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_data        (req_data),
      .box_constrained (box_ff),
      .upper_limit     (upper_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data)
   );

endmodule

// ----- sim/testbench.sv -----
// Testbench for box_constrained_babai_point: load, solve and CSR requests with random stalls.
// A built-in back-substitution predictor supplies the expected estimates; depends on bcbp_pkg.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   bcbp_pkg::req_type     req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   bcbp_pkg::rsp_type     rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index = bcbp_pkg::CSR_NONE;
   logic [7:0]            csr_data = '0;

   logic signed [bcbp_pkg::VALUE_WIDTH-1:0] tri_m [bcbp_pkg::MAX_SIZE][bcbp_pkg::MAX_SIZE];
   logic signed [bcbp_pkg::VALUE_WIDTH-1:0] target_v [bcbp_pkg::MAX_SIZE];
   logic signed [bcbp_pkg::EST_W-1:0]       est_v [bcbp_pkg::MAX_SIZE];
   logic [4:0] size_cfg = 5'd16;
   logic       box_cfg = 1'b1;
   logic [7:0] upper_cfg = 8'd3;

   bcbp_pkg::rsp_type estimate_q [$];
   int      errors = 0;
   bit      quiet = 1'b0;
   int      stall_left = 0;

   box_constrained_babai_point dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #50ms;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic signed [bcbp_pkg::EST_W-1:0] round_estimate(longint res,
                                                                        longint diag);
      longint rm, dm, q, rem;
      bit     neg;
      rm  = res < 0 ? -res : res;
      dm  = diag < 0 ? -diag : diag;
      neg = (res < 0) != (diag < 0);
      q   = rm / dm;
      rem = rm % dm;
      if (rem >= dm - rem) q++;
      if (q == 0) neg = 1'b0;
      if (box_cfg) begin
         if (neg) return '0;
         return q > upper_cfg ? bcbp_pkg::EST_W'(upper_cfg) : bcbp_pkg::EST_W'(q);
      end
      if (neg) return q > 32768 ? bcbp_pkg::EST_W'(-32768) : bcbp_pkg::EST_W'(-q);
      return q > 32767 ? bcbp_pkg::EST_W'(32767) : bcbp_pkg::EST_W'(q);
   endfunction

   function automatic void apply_request(bcbp_pkg::req_type r);
      int                n;
      longint            acc;
      bcbp_pkg::rsp_type e;
      case (bcbp_pkg::cmd_type'(r.command))
         bcbp_pkg::CMD_MATRIX: if (r.column >= r.row) tri_m[r.row][r.column] = r.entry_value;
         bcbp_pkg::CMD_TARGET: target_v[r.row] = r.entry_value;
         bcbp_pkg::CMD_SOLVE: begin
            n = size_cfg > bcbp_pkg::MAX_SIZE ? bcbp_pkg::MAX_SIZE : size_cfg;
            for (int i = n - 1; i >= 0; i--) begin
               acc = 0;
               for (int j = i + 1; j < n; j++)
                  acc += longint'(tri_m[i][j]) * longint'(est_v[j]);
               e.position   = 4'(i);
               e.zero_pivot = tri_m[i][i] == 0;
               e.estimate   = e.zero_pivot ? '0 :
                              round_estimate(longint'(target_v[i]) - acc,
                                             longint'(tri_m[i][i]));
               e.last       = i == 0;
               est_v[i]     = e.estimate;
               estimate_q.push_back(e);
            end
         end
         default: ;
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      bcbp_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (estimate_q.size() == 0) begin
            $error("unexpected result position %0d", rsp_data.position);
            errors++;
         end else begin
            e = estimate_q.pop_front();
            if (rsp_data.position !== e.position) begin
               $error("position expected %0d got %0d", e.position, rsp_data.position);
               errors++;
            end
            if (rsp_data.estimate !== e.estimate) begin
               $error("estimate expected %0d got %0d", e.estimate, rsp_data.estimate);
               errors++;
            end
            if (rsp_data.zero_pivot !== e.zero_pivot) begin
               $error("zero_pivot expected %0d got %0d", e.zero_pivot, rsp_data.zero_pivot);
               errors++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last expected %0d got %0d", e.last, rsp_data.last);
               errors++;
            end
         end
      end
   end

   // receiver stall bursts
   always @(posedge clock) begin
      if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic signed [bcbp_pkg::VALUE_WIDTH-1:0] rand_value();
      case ($urandom_range(0, 7))
         0: return bcbp_pkg::VALUE_WIDTH'($urandom);
         1: return 24'sh7FFFFF;
         2: return 24'sh800000;
         3: return '0;
         default: return bcbp_pkg::VALUE_WIDTH'(int'($urandom_range(0, 40000)) - 20000);
      endcase
   endfunction

   task automatic send_request(logic [1:0] cmd, logic [3:0] r, logic [3:0] c,
                               logic signed [bcbp_pkg::VALUE_WIDTH-1:0] v);
      bcbp_pkg::req_type q;
      q = '{command: cmd, row: r, column: c, entry_value: v};
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (req_stall);
      apply_request(q);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (estimate_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_csr(bcbp_pkg::csr_idx_type idx, logic [7:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         bcbp_pkg::CSR_SIZE:  size_cfg = d[4:0];
         bcbp_pkg::CSR_BOX:   box_cfg = d[0];
         bcbp_pkg::CSR_UPPER: upper_cfg = d;
         default: ;
      endcase
   endtask

   task automatic test_load_all();
      for (int r = 0; r < bcbp_pkg::MAX_SIZE; r++) begin
         for (int c = r; c < bcbp_pkg::MAX_SIZE; c++)
            send_request(bcbp_pkg::CMD_MATRIX, 4'(r), 4'(c),
                         c == r ? bcbp_pkg::VALUE_WIDTH'($urandom_range(1, 12000))
                                : rand_value());
         send_request(bcbp_pkg::CMD_TARGET, 4'(r), '0, rand_value());
      end
   endtask

   task automatic test_directed();
      send_request(bcbp_pkg::CMD_MATRIX, 4'd15, 4'd15, '0);
      send_request(bcbp_pkg::CMD_MATRIX, 4'd9, 4'd3, 24'sh7FFFFF);
      send_request(bcbp_pkg::CMD_NONE, 4'hF, 4'hF, 24'shFFFFFF);
      send_request(bcbp_pkg::CMD_MATRIX, 4'd14, 4'd14, 24'sh7FFFFF);
      send_request(bcbp_pkg::CMD_TARGET, 4'd14, '0, 24'sh800000);
      send_request(bcbp_pkg::CMD_MATRIX, 4'd0, 4'd0, 24'sh000800);
      send_request(bcbp_pkg::CMD_TARGET, 4'd0, '0, 24'sh000400);
      send_request(bcbp_pkg::CMD_SOLVE, '0, '0, '0);
      drain();
      write_csr(bcbp_pkg::CSR_BOX, 8'd0);
      send_request(bcbp_pkg::CMD_SOLVE, 4'hF, 4'hF, 24'shFFFFFF);
      drain();
      write_csr(bcbp_pkg::CSR_SIZE, 8'd1);
      send_request(bcbp_pkg::CMD_SOLVE, '0, '0, '0);
      drain();
      write_csr(bcbp_pkg::CSR_BOX, 8'd1);
      write_csr(bcbp_pkg::CSR_UPPER, 8'd255);
      write_csr(bcbp_pkg::CSR_SIZE, 8'd31);
      send_request(bcbp_pkg::CMD_SOLVE, '0, '0, '0);
      drain();
      write_csr(bcbp_pkg::CSR_UPPER, 8'd0);
      write_csr(bcbp_pkg::CSR_NONE, 8'hFF);
      send_request(bcbp_pkg::CMD_SOLVE, '0, '0, '0);
      drain();
      write_csr(bcbp_pkg::CSR_SIZE, 8'd0);
      send_request(bcbp_pkg::CMD_SOLVE, '0, '0, '0);
      drain();
   endtask

   task automatic test_random(int phases, int per_phase);
      int k;
      for (int p = 0; p < phases; p++) begin
         drain();
         write_csr(bcbp_pkg::CSR_SIZE, 8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                                   : $urandom_range(1, 16)));
         write_csr(bcbp_pkg::CSR_BOX, 8'($urandom_range(0, 1)));
         write_csr(bcbp_pkg::CSR_UPPER, 8'($urandom_range(0, 255)));
         for (int i = 0; i < per_phase; i++) begin
            k = $urandom_range(0, 15);
            if (k < 2)
               send_request(bcbp_pkg::CMD_SOLVE, 4'($urandom), 4'($urandom), rand_value());
            else if (k < 4)
               send_request(bcbp_pkg::CMD_TARGET, 4'($urandom), 4'($urandom), rand_value());
            else if (k == 4)
               send_request(bcbp_pkg::CMD_NONE, 4'($urandom), 4'($urandom), rand_value());
            else
               send_request(bcbp_pkg::CMD_MATRIX, 4'($urandom), 4'($urandom), rand_value());
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_load_all();
      test_directed();
      test_random(3, 45);
      quiet = 1'b1;
      test_random(1, 35);
      drain();
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
